FILE: hdl/xcfr_pkg.sv
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; xcfr_queue, xcfr_front, xcfr_back and the top import this package.
`default_nettype none

package xcfr_pkg;

  localparam int NUM_PORTS   = 5;
  localparam int MAX_PAYLOAD = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int PORT_W = 3;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_LT     = 8'h3C;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_EM,
    PH_LT,
    PH_SIZE,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

  // Good frame handed from parser to emitter
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        cmd;
    logic [LEN_W-1:0]  len;
  } desc_t;

  // Emitter tells the parser that a port's payload is free again
  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
  } done_t;

endpackage

`default_nettype wire

FILE: hdl/xcfr_if.sv
// Valid/ready channel interfaces for received bytes and emitted results.
// Depends on nothing; field widths follow the frame receiver's beats.
`default_nettype none

interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] port;
  logic [7:0] rx_byte;

  modport source (output valid, port, rx_byte, input ready);
  modport sink   (input valid, port, rx_byte, output ready);
endinterface

interface xcfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] src_port;
  logic [7:0] frame_command;
  logic [6:0] frame_length;
  logic       has_payload;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, src_port, frame_command, frame_length, has_payload,
                  byte_index, payload_byte, last, input ready);
  modport sink   (input valid, src_port, frame_command, frame_length, has_payload,
                  byte_index, payload_byte, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/xcfr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xcfr_queue.sv
// Short descriptor queue between the parser and the emitter.
// Depends on xcfr_pkg for desc_t.
`default_nettype none

module xcfr_queue import xcfr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t              slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/xcfr_front.sv
// Per-port frame parser: header match, size check, checksum, payload store writes.
// Depends on xcfr_pkg; feeds xcfr_queue and the payload RAM.
`default_nettype none

module xcfr_front import xcfr_pkg::*; #(
  parameter int PORTS  = NUM_PORTS,
  parameter int ADDR_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  xcfr_in_if.sink                in_ch,
  input  wire logic              q_full,
  input  wire done_t             done,
  output logic                   push,
  output desc_t                  push_desc,
  output logic                   wr_en,
  output logic      [ADDR_W-1:0] wr_addr,
  output logic      [7:0]        wr_data
);

  localparam int PI_W = (PORTS > 1) ? $clog2(PORTS) : 1;

  phase_t           phase_r [PORTS];
  phase_t           phase_nxt [PORTS];
  logic [7:0]       cmd_r   [PORTS];
  logic [7:0]       cmd_nxt [PORTS];
  logic [LEN_W-1:0] len_r   [PORTS];
  logic [LEN_W-1:0] len_nxt [PORTS];
  logic [7:0]       xor_r   [PORTS];
  logic [7:0]       xor_nxt [PORTS];
  logic [LEN_W-1:0] cnt_r   [PORTS];
  logic [LEN_W-1:0] cnt_nxt [PORTS];
  logic [PORTS-1:0] busy_r, busy_nxt;

  logic [PI_W-1:0]  pi;
  logic [PI_W-1:0]  done_pi;
  logic             port_ok;
  logic             acc;
  logic [7:0]       c;
  logic             in_body;

  assign pi      = PI_W'(in_ch.port);
  assign done_pi = PI_W'(done.port);
  assign port_ok = (int'(in_ch.port) < PORTS);
  assign c       = in_ch.rx_byte;

  // Hold a port whose last good frame is still queued or being emitted: its payload slots are in use.
  assign in_ch.ready = !q_full && !(port_ok && busy_r[pi]);
  assign acc         = in_ch.valid && in_ch.ready && port_ok;

  assign in_body = (cnt_r[pi] < len_r[pi]) && (cnt_r[pi] < LEN_W'(MAX_PAYLOAD));

  assign wr_addr = ADDR_W'(pi) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(cnt_r[pi]);
  assign wr_data = c;

  assign push_desc.port = in_ch.port;
  assign push_desc.cmd  = cmd_r[pi];
  assign push_desc.len  = len_r[pi];

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    wr_en     = 1'b0;
    push      = 1'b0;

    if (done.valid) begin
      busy_nxt[done_pi] = 1'b0;
    end

    if (acc) begin
      unique case (phase_r[pi])
        PH_IDLE: begin
          if (c == CH_DOLLAR) begin
            phase_nxt[pi] = PH_DOLLAR;
          end
        end
        PH_DOLLAR: phase_nxt[pi] = (c == CH_M)  ? PH_EM : PH_IDLE;
        PH_EM:     phase_nxt[pi] = (c == CH_LT) ? PH_LT : PH_IDLE;
        PH_LT: begin
          // Drop an oversized frame right at its size byte
          if (c > 8'(MAX_PAYLOAD)) begin
            phase_nxt[pi] = PH_IDLE;
          end else begin
            len_nxt[pi]   = LEN_W'(c);
            xor_nxt[pi]   = c;
            phase_nxt[pi] = PH_SIZE;
          end
        end
        PH_SIZE: begin
          cmd_nxt[pi]   = c;
          xor_nxt[pi]   = xor_r[pi] ^ c;
          cnt_nxt[pi]   = '0;
          phase_nxt[pi] = PH_BODY;
        end
        PH_BODY: begin
          if (in_body) begin
            wr_en       = 1'b1;
            xor_nxt[pi] = xor_r[pi] ^ c;
            cnt_nxt[pi] = cnt_r[pi] + 1'b1;
          end else begin
            // Checksum byte: hand a good frame to the emitter, drop a bad one
            if (xor_r[pi] == c) begin
              push         = 1'b1;
              busy_nxt[pi] = 1'b1;
            end
            phase_nxt[pi] = PH_IDLE;
          end
        end
        default: phase_nxt[pi] = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '{default: PH_IDLE};
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    len_r <= len_nxt;
    xor_r <= xor_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/xcfr_back.sv
// Frame emitter: pops good-frame descriptors and streams payload beats from the RAM.
// Depends on xcfr_pkg; reads the payload RAM, releases ports back to xcfr_front.
`default_nettype none

module xcfr_back import xcfr_pkg::*; #(
  parameter int ADDR_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire desc_t             head,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  output done_t                  done,
  xcfr_out_if.source             out_ch
);

  back_state_t       state_r, state_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              has_r, has_nxt;
  logic              last_r, last_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [PORT_W-1:0] rd_port;

  assign rd_addr = ADDR_W'(rd_port) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(idx_nxt);

  assign out_ch.valid         = (state_r == BK_SHOW);
  assign out_ch.src_port      = port_r;
  assign out_ch.frame_command = cmd_r;
  assign out_ch.frame_length  = len_r;
  assign out_ch.has_payload   = has_r;
  assign out_ch.byte_index    = idx_r;
  assign out_ch.payload_byte  = byte_r;
  assign out_ch.last          = last_r;

  always_comb begin
    state_nxt  = state_r;
    port_nxt   = port_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    has_nxt    = has_r;
    last_nxt   = last_r;
    byte_nxt   = byte_r;
    rd_port    = port_r;
    pop        = 1'b0;
    rd_en      = 1'b0;
    done.valid = 1'b0;
    done.port  = port_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          port_nxt = head.port;
          cmd_nxt  = head.cmd;
          len_nxt  = head.len;
          idx_nxt  = '0;
          rd_port  = head.port;
          if (head.len == '0) begin
            // Empty frame: one beat with no payload
            has_nxt   = 1'b0;
            byte_nxt  = '0;
            last_nxt  = 1'b1;
            state_nxt = BK_SHOW;
          end else begin
            rd_en     = 1'b1;
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: begin
        byte_nxt  = rd_data;
        has_nxt   = 1'b1;
        last_nxt  = ((LEN_W'(idx_r) + 1'b1) == len_r);
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_ch.ready) begin
          if (last_r) begin
            done.valid = 1'b1;
            state_nxt  = BK_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            rd_en     = 1'b1;
            state_nxt = BK_READ;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r <= port_nxt;
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/xor_checked_frame_receiver_top.sv
// Flow: a good frame's checksum beat goes into the frame queue; with the emitter free,
//   it is popped and its first payload byte is read from the RAM before the first result
//   beat is valid (no read for an empty frame); later beats are read in turn as each is taken.
// Throughput: one input beat per cycle; an input beat for a port whose previous
//   frame is still queued or being emitted, or any beat while the frame queue is full, waits.
// Reset: synchronous, active low; all ports go idle, queue and emitter empty.
`default_nettype none

module xor_checked_frame_receiver_top import xcfr_pkg::*; #(
  parameter int PORTS = NUM_PORTS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  xcfr_in_if.sink    in_ch,
  xcfr_out_if.source out_ch
);

  // Payload store: MAX_PAYLOAD bytes per port, port-major.
  localparam int STORE_DEPTH = PORTS * MAX_PAYLOAD;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic              push;
  desc_t             push_desc;
  desc_t             head;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  done_t             done;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // Front: parse every port's byte stream, write payload, queue good frames.
  xcfr_front #(
    .PORTS  (PORTS),
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .done      (done),
    .push      (push),
    .push_desc (push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Queue of good frames waiting for the emitter.
  xcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Payload bytes; the parser never writes a port the emitter is reading.
  xcfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Back: stream each queued frame as result beats, then release its port.
  xcfr_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (done),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
